@@ sv/arlld_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package arlld_pkg;

  localparam int unsigned OP_W       = 2;
  localparam int unsigned KEY_W      = 64;
  localparam int unsigned MASK_W     = 32;
  localparam int unsigned ARCH_NUM_W = 6;
  localparam int unsigned DELTA_W    = 16;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned CTR_W      = 32;

  // The outstanding delta is new - success - failure, two bits wider than a delta.
  localparam int unsigned ODELTA_W   = DELTA_W + 2;

  localparam logic [OP_W-1:0] OP_REGISTER   = 2'd0;
  localparam logic [OP_W-1:0] OP_UNREGISTER = 2'd1;
  localparam logic [OP_W-1:0] OP_UPDATE     = 2'd2;
  localparam logic [OP_W-1:0] OP_FIND_BEST  = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EXISTS      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_RUNNING = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL        = 3'd4;
  localparam logic [STATUS_W-1:0] ST_NO_AGENT    = 3'd5;

endpackage

`default_nettype wire

@@ sv/arlld_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module arlld_ram #(
  parameter int unsigned WIDTH  = 8,
  parameter int unsigned DEPTH  = 16,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read data holds its value until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

@@ sv/agent_registry_least_loaded_dispatch_unit.sv @@
// Agent registry with least-loaded dispatch.
// Requests come in on the in_valid_i / in_ready_o channel: register, unregister,
// update statistics or find the best agent for an archive. Each request produces
// exactly one response on out_valid_o / out_ready_i carrying status, chosen key
// and chosen load. The coordinator enable bit is written through the cfg channel,
// which is always ready; write it only while no request is in flight.
// The agent table lives in one RAM with a registered read port, and a single
// compare unit scans it one entry per cycle under a small sequencer. A scan
// stops early on a hit; an update then writes the entry back, and an
// unregister moves every later entry down one slot. Register and unregister
// with the coordinator disabled answer without a scan.
// Only one request is in flight: in_ready_o is low from acceptance until the
// response transfer completes and rises the cycle after. A stalled receiver
// simply holds the response.
// Reset empties the table (agent count to zero) and disables the coordinator;
// no clearing pass over the RAM is needed.
`timescale 1ns / 1ps
`default_nettype none

module agent_registry_least_loaded_dispatch_unit #(
  parameter int unsigned MAX_AGENTS   = 16,
  parameter int unsigned ARCHIVE_BITS = 32
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    rst_ni,

  input  wire logic                                    cfg_valid_i,
  output logic                                         cfg_ready_o,
  input  wire logic                                    cfg_coordinator_enabled_i,

  input  wire logic                                    in_valid_i,
  output logic                                         in_ready_o,
  input  wire logic [arlld_pkg::OP_W-1:0]              operation_i,
  input  wire logic [arlld_pkg::KEY_W-1:0]             agent_key_i,
  input  wire logic [arlld_pkg::MASK_W-1:0]            archive_mask_i,
  input  wire logic [arlld_pkg::ARCH_NUM_W-1:0]        archive_number_i,
  input  wire logic [arlld_pkg::DELTA_W-1:0]           success_delta_i,
  input  wire logic [arlld_pkg::DELTA_W-1:0]           failure_delta_i,
  input  wire logic [arlld_pkg::DELTA_W-1:0]           new_delta_i,

  output logic                                         out_valid_o,
  input  wire logic                                    out_ready_i,
  output logic      [arlld_pkg::STATUS_W-1:0]          status_o,
  output logic      [arlld_pkg::KEY_W-1:0]             chosen_key_o,
  output logic signed [arlld_pkg::CTR_W-1:0]           chosen_load_o
);

  import arlld_pkg::*;

  localparam int unsigned AW    = (MAX_AGENTS > 1) ? $clog2(MAX_AGENTS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_AGENTS + 1);

  // Table word layout, low to high: key, archive mask, outstanding, succeeded, failed.
  localparam int unsigned KEY_LO  = 0;
  localparam int unsigned MASK_LO = KEY_LO + KEY_W;
  localparam int unsigned OUT_LO  = MASK_LO + ARCHIVE_BITS;
  localparam int unsigned SUC_LO  = OUT_LO + CTR_W;
  localparam int unsigned FAIL_LO = SUC_LO + CTR_W;
  localparam int unsigned WORD_W  = FAIL_LO + CTR_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_UPD   = 3'd2;
  localparam logic [2:0] S_SH_RD = 3'd3;
  localparam logic [2:0] S_SH_WR = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]                 state_q, state_d;
  logic                       enabled_q;
  logic [CNT_W-1:0]           count_q, count_d;
  logic [CNT_W-1:0]           rd_idx_q, rd_idx_d;
  logic                       chk_vld_q, chk_vld_d;
  logic [AW-1:0]              chk_idx_q, chk_idx_d;
  logic [CNT_W-1:0]           sh_idx_q, sh_idx_d;
  logic                       found_q, found_d;

  logic [OP_W-1:0]            op_q, op_d;
  logic [KEY_W-1:0]           key_q, key_d;
  logic [MASK_W-1:0]          mask_q, mask_d;
  logic [ARCH_NUM_W-1:0]      arch_m1_q, arch_m1_d;
  logic                       arch_ok_q, arch_ok_d;
  logic [DELTA_W-1:0]         ds_q, ds_d;
  logic [DELTA_W-1:0]         df_q, df_d;
  logic [ODELTA_W-1:0]        dout_q, dout_d;
  logic                       clear_q, clear_d;

  logic [STATUS_W-1:0]        status_q, status_d;
  logic [KEY_W-1:0]           chosen_key_q, chosen_key_d;
  logic signed [CTR_W-1:0]    chosen_load_q, chosen_load_d;

  logic                       ram_we, ram_re;
  logic [AW-1:0]              ram_waddr, ram_raddr;
  logic [WORD_W-1:0]          ram_wdata, ram_rdata;

  logic [KEY_W-1:0]           rd_key;
  logic [ARCHIVE_BITS-1:0]    rd_mask;
  logic [ARCHIVE_BITS-1:0]    mask_sh;
  logic signed [CTR_W-1:0]    rd_load;
  logic [CTR_W-1:0]           rd_suc;
  logic [CTR_W-1:0]           rd_fail;
  logic                       key_hit;
  logic                       elig;
  logic                       better;
  logic                       hit;
  logic [CNT_W-1:0]           sh_next;

  assign rd_key  = ram_rdata[KEY_LO +: KEY_W];
  assign rd_mask = ram_rdata[MASK_LO +: ARCHIVE_BITS];
  assign rd_load = signed'(ram_rdata[OUT_LO +: CTR_W]);
  assign rd_suc  = ram_rdata[SUC_LO +: CTR_W];
  assign rd_fail = ram_rdata[FAIL_LO +: CTR_W];

  assign mask_sh = rd_mask >> arch_m1_q;
  assign key_hit = (rd_key == key_q);
  assign elig    = (rd_mask == '0) || (arch_ok_q && mask_sh[0]);
  assign better  = !found_q || (rd_load < chosen_load_q);
  assign sh_next = sh_idx_q + CNT_W'(1);

  // Scan stop: a key match, or for find best the first eligible idle agent.
  assign hit = chk_vld_q &&
               ((op_q == OP_FIND_BEST) ? (elig && (rd_load == '0)) : key_hit);

  assign cfg_ready_o   = 1'b1;
  assign in_ready_o    = (state_q == S_IDLE);
  assign out_valid_o   = (state_q == S_DONE);
  assign status_o      = status_q;
  assign chosen_key_o  = chosen_key_q;
  assign chosen_load_o = chosen_load_q;

  always_comb begin
    state_d       = state_q;
    count_d       = count_q;
    rd_idx_d      = rd_idx_q;
    chk_vld_d     = 1'b0;
    chk_idx_d     = chk_idx_q;
    sh_idx_d      = sh_idx_q;
    found_d       = found_q;
    op_d          = op_q;
    key_d         = key_q;
    mask_d        = mask_q;
    arch_m1_d     = arch_m1_q;
    arch_ok_d     = arch_ok_q;
    ds_d          = ds_q;
    df_d          = df_q;
    dout_d        = dout_q;
    clear_d       = clear_q;
    status_d      = status_q;
    chosen_key_d  = chosen_key_q;
    chosen_load_d = chosen_load_q;
    ram_we        = 1'b0;
    ram_waddr     = chk_idx_q;
    ram_wdata     = ram_rdata;
    ram_re        = 1'b0;
    ram_raddr     = rd_idx_q[AW-1:0];

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d          = operation_i;
          key_d         = agent_key_i;
          mask_d        = archive_mask_i;
          arch_m1_d     = archive_number_i - ARCH_NUM_W'(1);
          arch_ok_d     = (archive_number_i != '0) && (32'(archive_number_i) <= ARCHIVE_BITS);
          ds_d          = success_delta_i;
          df_d          = failure_delta_i;
          dout_d        = ODELTA_W'(new_delta_i) - ODELTA_W'(success_delta_i)
                          - ODELTA_W'(failure_delta_i);
          clear_d       = (success_delta_i == '0) && (failure_delta_i == '0) &&
                          (new_delta_i == '0);
          rd_idx_d      = '0;
          found_d       = 1'b0;
          status_d      = ST_OK;
          chosen_key_d  = '0;
          chosen_load_d = '0;
          if (((operation_i == OP_REGISTER) || (operation_i == OP_UNREGISTER)) && !enabled_q) begin
            status_d = ST_NOT_RUNNING;
            state_d  = S_DONE;
          end else begin
            state_d = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        if (chk_vld_q && (op_q == OP_FIND_BEST) && elig && better) begin
          found_d       = 1'b1;
          chosen_key_d  = rd_key;
          chosen_load_d = rd_load;
        end
        // Reads run one entry ahead of the compare; stop reading on a hit so
        // the matched entry stays in the read register.
        ram_re    = (rd_idx_q < count_q) && !hit;
        chk_vld_d = ram_re;
        if (ram_re) begin
          chk_idx_d = rd_idx_q[AW-1:0];
          rd_idx_d  = rd_idx_q + CNT_W'(1);
        end
        if (hit) begin
          case (op_q)
            OP_REGISTER: begin
              status_d = ST_EXISTS;
              state_d  = S_DONE;
            end
            OP_UNREGISTER: begin
              sh_idx_d = CNT_W'(chk_idx_q);
              state_d  = S_SH_RD;
            end
            OP_UPDATE: begin
              state_d = S_UPD;
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end else if (!chk_vld_q && (rd_idx_q >= count_q)) begin
          state_d = S_DONE;
          case (op_q)
            OP_REGISTER: begin
              if (count_q == CNT_W'(MAX_AGENTS)) begin
                status_d = ST_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = count_q[AW-1:0];
                ram_wdata = {{(3 * CTR_W){1'b0}}, ARCHIVE_BITS'(mask_q), key_q};
                count_d   = count_q + CNT_W'(1);
              end
            end
            OP_UNREGISTER, OP_UPDATE: begin
              status_d = ST_NOT_FOUND;
            end
            default: begin
              status_d = found_q ? ST_OK : ST_NO_AGENT;
            end
          endcase
        end
      end

      S_UPD: begin
        ram_we    = 1'b1;
        ram_waddr = chk_idx_q;
        if (clear_q) begin
          ram_wdata = {{(3 * CTR_W){1'b0}}, rd_mask, rd_key};
        end else begin
          ram_wdata = {rd_fail + CTR_W'(df_q),
                       rd_suc + CTR_W'(ds_q),
                       unsigned'(rd_load) + {{(CTR_W - ODELTA_W){dout_q[ODELTA_W-1]}}, dout_q},
                       rd_mask, rd_key};
        end
        state_d = S_DONE;
      end

      S_SH_RD: begin
        if (sh_next < count_q) begin
          ram_re    = 1'b1;
          ram_raddr = sh_next[AW-1:0];
          state_d   = S_SH_WR;
        end else begin
          count_d = count_q - CNT_W'(1);
          state_d = S_DONE;
        end
      end

      S_SH_WR: begin
        ram_we    = 1'b1;
        ram_waddr = sh_idx_q[AW-1:0];
        ram_wdata = ram_rdata;
        sh_idx_d  = sh_next;
        state_d   = S_SH_RD;
      end

      S_DONE: begin
        if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      enabled_q <= 1'b0;
      count_q   <= '0;
      rd_idx_q  <= '0;
      chk_vld_q <= 1'b0;
      sh_idx_q  <= '0;
      found_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      rd_idx_q  <= rd_idx_d;
      chk_vld_q <= chk_vld_d;
      sh_idx_q  <= sh_idx_d;
      found_q   <= found_d;
      if (cfg_valid_i && cfg_ready_o) begin
        enabled_q <= cfg_coordinator_enabled_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    chk_idx_q     <= chk_idx_d;
    op_q          <= op_d;
    key_q         <= key_d;
    mask_q        <= mask_d;
    arch_m1_q     <= arch_m1_d;
    arch_ok_q     <= arch_ok_d;
    ds_q          <= ds_d;
    df_q          <= df_d;
    dout_q        <= dout_d;
    clear_q       <= clear_d;
    status_q      <= status_d;
    chosen_key_q  <= chosen_key_d;
    chosen_load_q <= chosen_load_d;
  end

  arlld_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAX_AGENTS),
    .ADDR_W(AW)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

endmodule

`default_nettype wire
